### rtl/tsc_pkg.sv
// Shared widths and register indexes for the touch sample calibration block.
package tsc_pkg;

   localparam int RAW_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int FLAGS_W = 4;
   localparam int OUT_W   = 12;
   localparam int CSR_IDX_W = 3;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RAW_MIN_X     = 3'd0;
   localparam csr_index_type CSR_RAW_MAX_X     = 3'd1;
   localparam csr_index_type CSR_RAW_MIN_Y     = 3'd2;
   localparam csr_index_type CSR_RAW_MAX_Y     = 3'd3;
   localparam csr_index_type CSR_SCREEN_WIDTH  = 3'd4;
   localparam csr_index_type CSR_SCREEN_HEIGHT = 3'd5;
   localparam csr_index_type CSR_ORIENTATION   = 3'd6;

   // Orientation flag bit positions.
   localparam int FLAG_INV_X  = 0;
   localparam int FLAG_INV_Y  = 1;
   localparam int FLAG_SWAP   = 2;
   localparam int FLAG_ROT180 = 3;

endpackage

### rtl/touch_sample_calibrate.sv
// Top level of the touch sample calibration block: sequencer, shared multiplier and divider.
// Each request carries one sample from a resistive touch controller: a pen-down flag and raw
// 12-bit X and Y readings. One response is produced per request. With the pen down, each axis
// is clamped to its calibrated raw window, scaled by (size - 1) and divided by the window width,
// then optionally inverted, swapped and rotated by 180 degrees; with the pen up the last raw
// and screen coordinates are repeated. The response also flags the start and end of a touch.
// Sequence: a pen-up request goes from idle straight to the hand-over state. A pen-down
// request passes, for each axis in turn, through a load state that forms the product and a
// divide state that yields TOP_W quotient bits, where TOP_W = min(COORD_BITS, 13), because
// both axes share one restoring divider that retires one quotient bit per cycle; it then
// enters the hand-over state. An axis with an empty window skips the divider. The request
// side is not ready while a sample is being worked on; a finished sample waits in the
// hand-over state until the output register is free, and the next request is taken once the
// previous response has been handed over. Configuration registers may be written at any time
// the block is idle and the write port is always ready. The internal axis range saturates at
// 2^COORD_BITS - 1.
module touch_sample_calibrate #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  tsc_pkg::csr_index_type           csr_index,
   input  logic [tsc_pkg::SIZE_W-1:0]       csr_wdata,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_pen_down,
   input  logic [tsc_pkg::RAW_W-1:0]        req_sample_x,
   input  logic [tsc_pkg::RAW_W-1:0]        req_sample_y,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_touching,
   output logic                             rsp_touch_began,
   output logic                             rsp_touch_ended,
   output logic [tsc_pkg::RAW_W-1:0]        rsp_raw_x_report,
   output logic [tsc_pkg::RAW_W-1:0]        rsp_raw_y_report,
   output logic [tsc_pkg::OUT_W-1:0]        rsp_screen_x,
   output logic [tsc_pkg::OUT_W-1:0]        rsp_screen_y
);
   import tsc_pkg::*;

   // The axis maximum never exceeds 2^SIZE_W - 2, so it needs at most SIZE_W bits, and the
   // quotient is never larger than the axis maximum.
   localparam int TOP_W  = (COORD_BITS < SIZE_W) ? COORD_BITS : SIZE_W;
   localparam int PROD_W = RAW_W + TOP_W;
   localparam int CNT_W  = $clog2(TOP_W);
   localparam int EXT_W  = 17;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // Configuration registers.
   logic [RAW_W-1:0]   raw_min_x_ff, raw_max_x_ff, raw_min_y_ff, raw_max_y_ff;
   logic [SIZE_W-1:0]  screen_width_ff, screen_height_ff;
   logic [FLAGS_W-1:0] orient_ff;

   // Sequencer and captured sample.
   logic [1:0]       state_ff, state_in;
   logic             axis_ff, axis_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pen_ff;
   logic [RAW_W-1:0] samp_x_ff, samp_y_ff;

   // Shared divider registers: partial remainder, divisor, and the dividend low bits that are
   // shifted out while the quotient bits are shifted in behind them.
   logic [RAW_W-1:0] rem_ff, rem_in;
   logic [RAW_W-1:0] dvs_ff, dvs_in;
   logic [TOP_W-1:0] quo_ff, quo_in;
   logic [TOP_W-1:0] map_x_ff, map_y_ff;

   // Kept state, which is also the response payload.
   logic             last_touching_ff;
   logic             began_ff, ended_ff;
   logic             rsp_valid_ff;
   logic [RAW_W-1:0] kept_raw_x_ff, kept_raw_y_ff;
   logic [OUT_W-1:0] kept_scr_x_ff, kept_scr_y_ff;

   // Axis maxima: size - 1 (a size of 0 acts as 1), saturated at 2^COORD_BITS - 1.
   logic [EXT_W-1:0] coord_mask;
   logic [EXT_W-1:0] top_x_ext, top_y_ext;
   logic [TOP_W-1:0] top_x, top_y;

   assign coord_mask = EXT_W'((64'd1 << COORD_BITS) - 64'd1);

   always_comb begin
      top_x_ext = (screen_width_ff == '0) ? '0 : EXT_W'(screen_width_ff - SIZE_W'(1));
      top_y_ext = (screen_height_ff == '0) ? '0 : EXT_W'(screen_height_ff - SIZE_W'(1));
      if (top_x_ext > coord_mask) begin
         top_x_ext = coord_mask;
      end
      if (top_y_ext > coord_mask) begin
         top_y_ext = coord_mask;
      end
   end

   assign top_x = top_x_ext[TOP_W-1:0];
   assign top_y = top_y_ext[TOP_W-1:0];

   // Operands of the axis currently being worked on.
   logic [RAW_W-1:0]  op_raw, op_lo, op_hi, op_clamp, op_diff;
   logic [TOP_W-1:0]  op_top;
   logic              op_empty;
   logic [PROD_W-1:0] op_prod;

   always_comb begin
      op_raw = axis_ff ? samp_y_ff : samp_x_ff;
      op_lo  = axis_ff ? raw_min_y_ff : raw_min_x_ff;
      op_hi  = axis_ff ? raw_max_y_ff : raw_max_x_ff;
      op_top = axis_ff ? top_y : top_x;
      op_empty = (op_hi <= op_lo);
      priority if (op_raw < op_lo) begin
         op_clamp = op_lo;
      end else if (op_raw > op_hi) begin
         op_clamp = op_hi;
      end else begin
         op_clamp = op_raw;
      end
      op_diff = op_clamp - op_lo;
      op_prod = PROD_W'(op_diff) * PROD_W'(op_top);
   end

   // One restoring division step: bring down the next dividend bit and try the subtraction.
   logic [RAW_W:0]   trial_rem;
   logic [RAW_W+1:0] trial_diff;
   logic             quo_bit;

   always_comb begin
      trial_rem  = {rem_ff, quo_ff[TOP_W-1]};
      trial_diff = {1'b0, trial_rem} - {2'b00, dvs_ff};
      quo_bit    = !trial_diff[RAW_W+1];
   end

   // Orientation stage on the two mapped values.
   logic [TOP_W-1:0] inv_x, inv_y, swp_x, swp_y, fin_x, fin_y;
   logic [SIZE_W-1:0] fin_x_ext, fin_y_ext;

   always_comb begin
      inv_x = orient_ff[FLAG_INV_X] ? (top_x - map_x_ff) : map_x_ff;
      inv_y = orient_ff[FLAG_INV_Y] ? (top_y - map_y_ff) : map_y_ff;
      swp_x = orient_ff[FLAG_SWAP] ? inv_y : inv_x;
      swp_y = orient_ff[FLAG_SWAP] ? inv_x : inv_y;
      if (orient_ff[FLAG_ROT180]) begin
         fin_x = (swp_x > top_x) ? '0 : (top_x - swp_x);
         fin_y = (swp_y > top_y) ? '0 : (top_y - swp_y);
      end else begin
         fin_x = swp_x;
         fin_y = swp_y;
      end
      fin_x_ext = SIZE_W'(fin_x);
      fin_y_ext = SIZE_W'(fin_y);
   end

   logic accept_req;
   logic out_free;
   logic finish;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept_req = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == S_DONE) && out_free;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_req) begin
               axis_in  = 1'b0;
               state_in = req_pen_down ? S_LOAD : S_DONE;
            end
         end
         S_LOAD: begin
            if (op_empty) begin
               // An empty window maps to zero; the divider is skipped for this axis.
               quo_in = '0;
               if (axis_ff) begin
                  state_in = S_DONE;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               rem_in   = op_prod[PROD_W-1:TOP_W];
               quo_in   = op_prod[TOP_W-1:0];
               dvs_in   = op_hi - op_lo;
               cnt_in   = CNT_W'(TOP_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = quo_bit ? trial_diff[RAW_W-1:0] : trial_rem[RAW_W-1:0];
            quo_in = {quo_ff[TOP_W-2:0], quo_bit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (axis_ff) begin
                  state_in = S_DONE;
               end else begin
                  axis_in  = 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         last_touching_ff <= 1'b0;
         began_ff         <= 1'b0;
         ended_ff         <= 1'b0;
         kept_raw_x_ff    <= '0;
         kept_raw_y_ff    <= '0;
         kept_scr_x_ff    <= '0;
         kept_scr_y_ff    <= '0;
         raw_min_x_ff     <= '0;
         raw_max_x_ff     <= RAW_W'(4095);
         raw_min_y_ff     <= '0;
         raw_max_y_ff     <= RAW_W'(4095);
         screen_width_ff  <= SIZE_W'(320);
         screen_height_ff <= SIZE_W'(240);
         orient_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_RAW_MIN_X:     raw_min_x_ff     <= csr_wdata[RAW_W-1:0];
               CSR_RAW_MAX_X:     raw_max_x_ff     <= csr_wdata[RAW_W-1:0];
               CSR_RAW_MIN_Y:     raw_min_y_ff     <= csr_wdata[RAW_W-1:0];
               CSR_RAW_MAX_Y:     raw_max_y_ff     <= csr_wdata[RAW_W-1:0];
               CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               CSR_ORIENTATION:   orient_ff        <= csr_wdata[FLAGS_W-1:0];
               default: begin
               end
            endcase
         end
         if (finish) begin
            rsp_valid_ff     <= 1'b1;
            last_touching_ff <= pen_ff;
            began_ff         <= pen_ff && !last_touching_ff;
            ended_ff         <= !pen_ff && last_touching_ff;
            if (pen_ff) begin
               kept_raw_x_ff <= samp_x_ff;
               kept_raw_y_ff <= samp_y_ff;
               kept_scr_x_ff <= fin_x_ext[OUT_W-1:0];
               kept_scr_y_ff <= fin_y_ext[OUT_W-1:0];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      if (accept_req) begin
         pen_ff    <= req_pen_down;
         samp_x_ff <= req_sample_x;
         samp_y_ff <= req_sample_y;
      end
      // Capture each axis result as it leaves the divider or the empty-window bypass.
      if ((state_ff == S_LOAD && op_empty) || (state_ff == S_DIV && cnt_ff == '0)) begin
         if (axis_ff) begin
            map_y_ff <= quo_in;
         end else begin
            map_x_ff <= quo_in;
         end
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touching     = last_touching_ff;
   assign rsp_touch_began  = began_ff;
   assign rsp_touch_ended  = ended_ff;
   assign rsp_raw_x_report = kept_raw_x_ff;
   assign rsp_raw_y_report = kept_raw_y_ff;
   assign rsp_screen_x     = kept_scr_x_ff;
   assign rsp_screen_y     = kept_scr_y_ff;

`ifndef SYNTHESIS
   // A response only appears when the sequencer hands over a finished sample.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the hand-over state");

   // The partial remainder must stay below the divisor throughout the division.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   // A touch cannot begin and end on the same sample, and a beginning implies contact.
   a_edge_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!(began_ff && ended_ff) && (!began_ff || last_touching_ff)))
      else $error("inconsistent touch edge flags");

   // A response still waiting must not be dropped before it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending response dropped");
`endif

endmodule
